@@ rtl/crcpf_pkg.sv @@
// Shared types and constants for the CRC-8 packet framer.
// Used by crcpf_core, crc8_packet_framer and crcpf_check; depends on nothing.
package crcpf_pkg;

  // Command codes carried in the command field
  localparam logic CMD_OPEN = 1'b0;
  localparam logic CMD_DATA = 1'b1;

  // Frame constants
  localparam logic [7:0] FRAME_START = 8'hAA;
  localparam logic [7:0] CRC_POLY    = 8'h07;
  localparam logic [7:0] CRC_TOPBIT  = 8'h80;

  // Largest number of bytes one request can produce: header plus CRC
  localparam int MAX_RES = 5;
  localparam int CNT_W   = $clog2(MAX_RES + 1);

  typedef struct packed {
    logic        command;
    logic [7:0]  pkt_type;
    logic [15:0] pkt_len;
    logic [7:0]  data_byte;
  } cmd_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       end_of_packet;
  } tx_t;

  // Bytes produced by one request, in send order from entry 0
  typedef struct packed {
    tx_t [MAX_RES-1:0] item;
    logic [CNT_W-1:0]  count;
  } burst_t;

  // Fold one byte into the CRC-8, MSB first
  function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOPBIT) != 8'h00) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ rtl/crcpf_core.sv @@
// Packet state and byte builder: turns one accepted request into a burst of bytes.
// Depends on crcpf_pkg.
module crcpf_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  crcpf_pkg::cmd_t     cmd,
  output crcpf_pkg::burst_t   burst
);

  logic [7:0]  running_crc;
  logic [15:0] bytes_remaining;
  logic        packet_open;

  logic [7:0]  running_crc_next;
  logic [15:0] bytes_remaining_next;
  logic        packet_open_next;

  logic [7:0]  crc_new;
  logic [15:0] rem_dec;

  assign crc_new = crcpf_pkg::crc_fold(running_crc, cmd.data_byte);
  assign rem_dec = bytes_remaining - 16'd1;

  // Build the bytes for this request and the state it leaves behind
  always_comb begin
    burst                = '0;
    running_crc_next     = running_crc;
    bytes_remaining_next = bytes_remaining;
    packet_open_next     = packet_open;
    if (cmd.command == crcpf_pkg::CMD_OPEN) begin
      burst.item[0] = '{tx_byte: crcpf_pkg::FRAME_START, end_of_packet: 1'b0};
      burst.item[1] = '{tx_byte: cmd.pkt_type,           end_of_packet: 1'b0};
      burst.item[2] = '{tx_byte: cmd.pkt_len[15:8],      end_of_packet: 1'b0};
      burst.item[3] = '{tx_byte: cmd.pkt_len[7:0],       end_of_packet: 1'b0};
      running_crc_next     = 8'h00;
      bytes_remaining_next = cmd.pkt_len;
      packet_open_next     = (cmd.pkt_len != 16'd0);
      if (cmd.pkt_len == 16'd0) begin
        // empty packet: CRC of nothing follows at once
        burst.item[4] = '{tx_byte: 8'h00, end_of_packet: 1'b1};
        burst.count   = crcpf_pkg::CNT_W'(5);
      end else begin
        burst.count   = crcpf_pkg::CNT_W'(4);
      end
    end else if (packet_open) begin
      burst.item[0]        = '{tx_byte: cmd.data_byte, end_of_packet: 1'b0};
      bytes_remaining_next = rem_dec;
      if (rem_dec == 16'd0) begin
        // last payload byte: append CRC and close
        burst.item[1]    = '{tx_byte: crc_new, end_of_packet: 1'b1};
        burst.count      = crcpf_pkg::CNT_W'(2);
        running_crc_next = 8'h00;
        packet_open_next = 1'b0;
      end else begin
        burst.count      = crcpf_pkg::CNT_W'(1);
        running_crc_next = crc_new;
      end
    end
    // payload with no packet open: drop, count stays zero
  end

  // Advance packet state on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc     <= 8'h00;
      bytes_remaining <= 16'd0;
      packet_open     <= 1'b0;
    end else if (load) begin
      running_crc     <= running_crc_next;
      bytes_remaining <= bytes_remaining_next;
      packet_open     <= packet_open_next;
    end
  end

endmodule

@@ rtl/crc8_packet_framer.sv @@
// CRC-8 packet framer top level: burst buffer and output register.
// A request's bytes go from the burst buffer (held) into the output register (tx) in turn.
// Throughput: one request per cycle while each yields at most one byte and the output
//   is not stalled; a longer burst holds the input until its last byte leaves the buffer.
// Reset (rst, synchronous): no packet open, CRC and count cleared, buffers empty.
// Depends on crcpf_pkg and crcpf_core.
module crc8_packet_framer (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  crcpf_pkg::cmd_t   cmd,
  output logic              tx_valid,
  input  logic              tx_ready,
  output crcpf_pkg::tx_t    tx
);

  crcpf_pkg::burst_t           burst;
  crcpf_pkg::burst_t           held;
  logic [crcpf_pkg::CNT_W-1:0] idx;
  logic                        held_has;
  logic                        pop;
  logic                        last_pop;
  logic                        load;

  crcpf_core u_core (
    .clk   (clk),
    .rst   (rst),
    .load  (load),
    .cmd   (cmd),
    .burst (burst)
  );

  // Move a byte to the output register whenever it is free or being taken
  assign held_has  = (idx != held.count);
  assign pop       = held_has && (!tx_valid || tx_ready);
  assign last_pop  = pop && (idx == held.count - crcpf_pkg::CNT_W'(1));
  assign cmd_ready = !held_has || last_pop;
  assign load      = cmd_valid && cmd_ready;

  // Hold the burst of the latest request and step through it
  always_ff @(posedge clk) begin
    if (rst) begin
      held.count <= '0;
      idx        <= '0;
    end else if (load) begin
      held.count <= burst.count;
      held.item  <= burst.item;
      idx        <= '0;
    end else if (pop) begin
      idx <= idx + crcpf_pkg::CNT_W'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      tx_valid <= 1'b0;
    end else if (pop) begin
      tx_valid <= 1'b1;
    end else if (tx_ready) begin
      tx_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      tx <= held.item[idx];
    end
  end

endmodule

@@ rtl/crcpf_check.sv @@
// Port-level checks for the CRC-8 packet framer, bound to the top level.
// Depends on crcpf_pkg and crc8_packet_framer.
module crcpf_check (
  input logic              clk,
  input logic              rst,
  input logic              cmd_valid,
  input logic              cmd_ready,
  input crcpf_pkg::cmd_t   cmd,
  input logic              tx_valid,
  input logic              tx_ready,
  input crcpf_pkg::tx_t    tx
);

  // Reset leaves the output empty and the input open for a request
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!tx_valid && cmd_ready))
    else $error("framer not empty after reset");

  // An open request queues at least four bytes, so the next request must wait
  a_open_blocks: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready && cmd.command == crcpf_pkg::CMD_OPEN) |=> !cmd_ready)
    else $error("request taken while header still pending");

  // A stalled output byte holds
  a_tx_hold: assert property (@(posedge clk) disable iff (rst)
    (tx_valid && !tx_ready) |=> (tx_valid && $stable(tx)))
    else $error("output byte changed while stalled");

endmodule

bind crc8_packet_framer crcpf_check u_crcpf_check (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_ready (cmd_ready),
  .cmd       (cmd),
  .tx_valid  (tx_valid),
  .tx_ready  (tx_ready),
  .tx        (tx)
);

@@ tb/crcpf_check.sv @@
// Checker for the CRC-8 packet framer: models the framing of every accepted request
// and compares each byte sent on the tx channel with the oldest byte still due.
// Depends on crcpf_pkg; instantiated beside the block by tb.
module crcpf_scoreboard (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cmd_valid,
  input  logic                    cmd_ready,
  input  crcpf_pkg::cmd_t         cmd,
  input  logic                    tx_valid,
  input  logic                    tx_ready,
  input  crcpf_pkg::tx_t          tx,
  output int                      fail_count,
  output int                      bytes_due
);

  // Framing state as the block should hold it
  logic [7:0]  crc_acc      = '0;
  logic [15:0] payload_left = '0;
  logic        frame_open   = 1'b0;

  crcpf_pkg::tx_t frame_bytes_due[$];
  crcpf_pkg::tx_t want;
  int             errors = 0;

  // Fold one byte into the SMBus CRC-8, MSB first
  function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] r;
    logic       msb;
    r = acc ^ b;
    repeat (8) begin
      msb = r[7];
      r = r << 1;
      if (msb) begin
        r = r ^ crcpf_pkg::CRC_POLY;
      end
    end
    return r;
  endfunction

  // Work out the bytes one request should put on the wire, and advance the state
  task automatic frame_request(input crcpf_pkg::cmd_t c);
    if (c.command == crcpf_pkg::CMD_OPEN) begin
      frame_bytes_due.push_back(
        crcpf_pkg::tx_t'{tx_byte: crcpf_pkg::FRAME_START, end_of_packet: 1'b0});
      frame_bytes_due.push_back(
        crcpf_pkg::tx_t'{tx_byte: c.pkt_type, end_of_packet: 1'b0});
      frame_bytes_due.push_back(
        crcpf_pkg::tx_t'{tx_byte: c.pkt_len[15:8], end_of_packet: 1'b0});
      frame_bytes_due.push_back(
        crcpf_pkg::tx_t'{tx_byte: c.pkt_len[7:0], end_of_packet: 1'b0});
      crc_acc = '0;
      if (c.pkt_len == 16'h0000) begin
        // Empty packet: close at once with a zero CRC
        frame_bytes_due.push_back(crcpf_pkg::tx_t'{tx_byte: 8'h00, end_of_packet: 1'b1});
        payload_left = '0;
        frame_open   = 1'b0;
      end else begin
        payload_left = c.pkt_len;
        frame_open   = 1'b1;
      end
    end else if (frame_open) begin
      frame_bytes_due.push_back(
        crcpf_pkg::tx_t'{tx_byte: c.data_byte, end_of_packet: 1'b0});
      crc_acc      = crc8_step(crc_acc, c.data_byte);
      payload_left = payload_left - 16'd1;
      if (payload_left == 16'h0000) begin
        // Last payload byte: append the CRC and close
        frame_bytes_due.push_back(crcpf_pkg::tx_t'{tx_byte: crc_acc, end_of_packet: 1'b1});
        frame_open = 1'b0;
        crc_acc    = '0;
      end
    end
    // Payload with no packet open: drop it
  endtask

  // Compare sent bytes first, then model the request taken at the same edge
  always @(posedge clk) begin
    if (rst) begin
      crc_acc      = '0;
      payload_left = '0;
      frame_open   = 1'b0;
      frame_bytes_due.delete();
    end else begin
      if (tx_valid && tx_ready) begin
        if (frame_bytes_due.size() == 0) begin
          $error("tx_byte: expected none, actual %02h", tx.tx_byte);
          errors++;
        end else begin
          want = frame_bytes_due.pop_front();
          if (tx.tx_byte !== want.tx_byte) begin
            $error("tx_byte: expected %02h, actual %02h", want.tx_byte, tx.tx_byte);
            errors++;
          end
          if (tx.end_of_packet !== want.end_of_packet) begin
            $error("end_of_packet: expected %0b, actual %0b",
                   want.end_of_packet, tx.end_of_packet);
            errors++;
          end
        end
      end
      if (cmd_valid && cmd_ready) begin
        frame_request(cmd);
      end
    end
    fail_count <= errors;
    bytes_due  <= frame_bytes_due.size();
  end

endmodule

@@ tb/tb.sv @@
// Testbench top for the CRC-8 packet framer: clock, reset, request stimulus with
// bursts and gaps, a stalling byte receiver and the verdict.
// Depends on crcpf_pkg, crc8_packet_framer and crcpf_scoreboard.
module tb;

  logic            clk;
  logic            rst;
  logic            cmd_valid;
  logic            cmd_ready;
  crcpf_pkg::cmd_t cmd;
  logic            tx_valid;
  logic            tx_ready;
  crcpf_pkg::tx_t  tx;
  int              fail_count;
  int              bytes_due;

  int   sent       = 0;
  int   burst_left = 0;
  logic long_hold_req  = 1'b0;
  logic long_hold_done = 1'b0;

  crc8_packet_framer dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .tx_valid  (tx_valid),
    .tx_ready  (tx_ready),
    .tx        (tx)
  );

  crcpf_scoreboard u_check (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .tx_valid   (tx_valid),
    .tx_ready   (tx_ready),
    .tx         (tx),
    .fail_count (fail_count),
    .bytes_due  (bytes_due)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Bound the run well beyond the slowest correct one
  initial begin
    #(12 * 300000);
    $display("Mismatches found");
    $finish;
  end

  // Open request; the unused payload byte carries noise
  function automatic crcpf_pkg::cmd_t open_req(input logic [7:0] kind,
                                               input logic [15:0] len);
    return crcpf_pkg::cmd_t'{command: crcpf_pkg::CMD_OPEN, pkt_type: kind, pkt_len: len,
                             data_byte: 8'($urandom)};
  endfunction

  // Payload request; the unused type and length carry noise
  function automatic crcpf_pkg::cmd_t data_req(input logic [7:0] b);
    return crcpf_pkg::cmd_t'{command: crcpf_pkg::CMD_DATA, pkt_type: 8'($urandom),
                             pkt_len: 16'($urandom), data_byte: b};
  endfunction

  // Offer one request, opening a random gap between bursts, and hold until taken
  task automatic put_request(input crcpf_pkg::cmd_t c);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
        cmd_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    cmd_valid <= 1'b1;
    cmd       <= c;
    do @(posedge clk); while (!cmd_ready);
    sent++;
  endtask

  // Stop offering until every byte due has been sent
  task automatic drain();
    cmd_valid  <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (bytes_due != 0) @(posedge clk);
  endtask

  // Receiver: stall on a changing pattern, with one long hold-off on request
  initial begin : rx_side
    int mode;
    int phase;
    mode     = 0;
    phase    = 0;
    tx_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req && !long_hold_done) begin
        tx_ready <= 1'b0;
        repeat (300) @(posedge clk);
        long_hold_done = 1'b1;
      end
      case (mode)
        0: tx_ready <= 1'b1;
        1: tx_ready <= ($urandom_range(0, 1) == 1);
        2: tx_ready <= ($urandom_range(0, 3) == 0);
        default: tx_ready <= phase[0];
      endcase
      phase++;
      if (phase == 40) begin
        phase = 0;
        mode  = $urandom_range(0, 3);
      end
    end
  end

  // Stimulus and verdict
  initial begin
    int          pick;
    int          nbytes;
    logic [15:0] len;
    logic        paused;
    paused    = 1'b0;
    rst       = 1'b1;
    cmd_valid = 1'b0;
    cmd       = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Stray payload before any open: drop
    put_request(data_req(8'hFF));
    // Empty packets at both type extremes
    put_request(open_req(8'h00, 16'h0000));
    put_request(open_req(8'hFF, 16'h0000));
    // Single-byte packet
    put_request(open_req(8'h5A, 16'h0001));
    put_request(data_req(8'h00));
    // Short packet with extreme bytes
    put_request(open_req(8'hFF, 16'h0003));
    put_request(data_req(8'hFF));
    put_request(data_req(8'h80));
    put_request(data_req(8'h01));
    // Stray payload after close: drop
    put_request(data_req(8'h55));
    // Longest declared length, abandoned by a new open
    put_request(open_req(8'hA5, 16'hFFFF));
    put_request(data_req(8'h12));
    put_request(data_req(8'h34));
    put_request(open_req(8'h3C, 16'h0002));
    put_request(data_req(8'hFF));
    put_request(data_req(8'hFF));
    // Top length bit set, abandoned again
    put_request(open_req(8'h81, 16'h8001));
    put_request(data_req(8'h7E));
    drain();

    // Random packets, mostly well formed, some truncated, some stray bytes
    while (sent < 224) begin
      if (!long_hold_req && sent >= 100) begin
        long_hold_req <= 1'b1;
        burst_left = 80;
      end
      if (!paused && sent >= 170) begin
        drain();
        paused = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        put_request(data_req(8'($urandom)));
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          len = 16'h0000;
        end else if (pick < 85) begin
          len = 16'($urandom_range(1, 8));
        end else begin
          len = 16'($urandom_range(9, 65535));
        end
        put_request(open_req(8'($urandom), len));
        if (len > 16'd12) begin
          nbytes = $urandom_range(0, 6);
        end else if ($urandom_range(0, 9) == 0) begin
          nbytes = $urandom_range(0, int'(len));
        end else begin
          nbytes = int'(len);
        end
        repeat (nbytes) put_request(data_req(8'($urandom)));
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
